FILE: hw/rtl/dzmt_pkg.sv
// Shared constants, action and register codes, control structs and modular
// arithmetic for the divisor zeta / Moebius transform block.
// No dependencies.
package dzmt_pkg;

   localparam int DATA_W        = 30;
   localparam int IDX_W         = 10;
   localparam int SIZE_W        = 11;
   localparam int ACTION_W      = 2;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 11;
   localparam int DEFAULT_DEPTH = 1024;
   localparam int SIEVE_LIMIT   = 2048;

   localparam logic [DATA_W-1:0] MODULUS = 30'd998244353;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_XFORM = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE = 1'd1;

   typedef struct packed {
      logic              start;
      logic              mode;
      logic [SIZE_W-1:0] size;
   } xform_ctl_type;

   typedef struct packed {
      logic              re;
      logic [SIZE_W-1:0] raddr;
      logic              we;
      logic [SIZE_W-1:0] waddr;
      logic [DATA_W-1:0] wdata;
   } xform_mem_type;

   function automatic logic [DATA_W-1:0] mod_add(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      logic [DATA_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, MODULUS}) begin
         s = s - {1'b0, MODULUS};
      end
      return s[DATA_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] mod_sub(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      logic [DATA_W:0] d;
      d = {1'b0, a} - {1'b0, b};
      if (a < b) begin
         d = d + {1'b0, MODULUS};
      end
      return d[DATA_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/dzmt_req_if.sv
// Request channel: valid/ready handshake carrying action, index and value.
// Depends on dzmt_pkg.
interface dzmt_req_if;
   logic                          valid;
   logic                          ready;
   logic [dzmt_pkg::ACTION_W-1:0] action;
   logic [dzmt_pkg::IDX_W-1:0]    index;
   logic [dzmt_pkg::DATA_W-1:0]   value;

   modport source (output valid, output action, output index, output value, input ready);
   modport sink   (input valid, input action, input index, input value, output ready);
endinterface

FILE: hw/rtl/dzmt_rsp_if.sv
// Response channel: valid/ready handshake carrying read_value.
// Depends on dzmt_pkg.
interface dzmt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dzmt_pkg::DATA_W-1:0] read_value;

   modport source (output valid, output read_value, input ready);
   modport sink   (input valid, input read_value, output ready);
endinterface

FILE: hw/rtl/dzmt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dzmt_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/dzmt_xform.sv
// Transform sequencer: sieve refill, prime scan and read-modify-write passes
// over the element memory. Owns the sieve RAM.
// Depends on dzmt_pkg and dzmt_ram.
module dzmt_xform #(
   parameter int ARRAY_DEPTH = dzmt_pkg::DEFAULT_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dzmt_pkg::xform_ctl_type     ctl,
   input  logic [dzmt_pkg::DATA_W-1:0] elem_rdata,
   output dzmt_pkg::xform_mem_type     mem,
   output logic                        done
);

   localparam int SIEVE_DEPTH = (ARRAY_DEPTH < dzmt_pkg::SIEVE_LIMIT) ?
                                ARRAY_DEPTH : dzmt_pkg::SIEVE_LIMIT;
   localparam int SAW = $clog2(SIEVE_DEPTH);
   localparam int NW  = dzmt_pkg::SIZE_W;

   localparam logic [2:0] X_IDLE  = 3'd0;
   localparam logic [2:0] X_CLEAR = 3'd1;
   localparam logic [2:0] X_SCAN  = 3'd2;
   localparam logic [2:0] X_CHECK = 3'd3;
   localparam logic [2:0] X_MARK  = 3'd4;
   localparam logic [2:0] X_RDK   = 3'd5;
   localparam logic [2:0] X_RDJ   = 3'd6;
   localparam logic [2:0] X_WR    = 3'd7;

   logic [2:0]                  state_ff, state_in;
   logic [NW-1:0]               i_ff, i_in;
   logic [NW-1:0]               j_ff, j_in;
   logic [NW-1:0]               k_ff, k_in;
   logic [NW-1:0]               m_ff, m_in;
   logic                        mode_ff, mode_in;
   logic [dzmt_pkg::DATA_W-1:0] hold_ff, hold_in;

   logic           sv_we, sv_re;
   logic [SAW-1:0] sv_waddr, sv_raddr;
   logic [0:0]     sv_wdata, sv_rdata;
   logic           next_fits;
   logic [NW:0]    k_next;

   dzmt_ram #(.WIDTH(1), .DEPTH(SIEVE_DEPTH)) u_sieve (
      .clock   (clock),
      .wr_en   (sv_we),
      .wr_addr (sv_waddr),
      .wr_data (sv_wdata),
      .rd_en   (sv_re),
      .rd_addr (sv_raddr),
      .rd_data (sv_rdata)
   );

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      m_in      = m_ff;
      mode_in   = mode_ff;
      hold_in   = hold_ff;
      mem       = '0;
      done      = 1'b0;
      sv_we     = 1'b0;
      sv_re     = 1'b0;
      sv_waddr  = SAW'(k_ff);
      sv_raddr  = SAW'(i_ff);
      sv_wdata  = 1'b0;
      k_next    = {1'b0, k_ff} + {1'b0, i_ff};
      next_fits = k_next < {1'b0, m_ff};

      case (state_ff)
         X_IDLE: begin
            if (ctl.start) begin
               mode_in  = ctl.mode;
               m_in     = (32'(ctl.size) > ARRAY_DEPTH) ? NW'(ARRAY_DEPTH) : ctl.size;
               i_in     = NW'(2);
               state_in = X_CLEAR;
            end
         end
         X_CLEAR: begin
            if (i_ff < m_ff) begin
               sv_we    = 1'b1;
               sv_waddr = SAW'(i_ff);
               sv_wdata = 1'b1;
               i_in     = i_ff + NW'(1);
            end else begin
               i_in     = NW'(2);
               state_in = X_SCAN;
            end
         end
         X_SCAN: begin
            if (i_ff >= m_ff) begin
               done     = 1'b1;
               state_in = X_IDLE;
            end else begin
               sv_re    = 1'b1;
               state_in = X_CHECK;
            end
         end
         X_CHECK: begin
            if (!sv_rdata[0]) begin
               i_in     = i_ff + NW'(1);
               state_in = X_SCAN;
            end else begin
               j_in     = NW'(1);
               k_in     = i_ff;
               state_in = mode_ff ? X_RDK : X_MARK;
            end
         end
         X_MARK: begin
            sv_we = 1'b1;
            if (next_fits) begin
               j_in = j_ff + NW'(1);
               k_in = k_next[NW-1:0];
            end else begin
               state_in = X_RDK;
            end
         end
         X_RDK: begin
            mem.re    = 1'b1;
            mem.raddr = k_ff;
            state_in  = X_RDJ;
         end
         X_RDJ: begin
            mem.re    = 1'b1;
            mem.raddr = j_ff;
            hold_in   = elem_rdata;
            state_in  = X_WR;
         end
         X_WR: begin
            mem.we    = 1'b1;
            mem.waddr = j_ff;
            if (mode_ff) begin
               mem.wdata = dzmt_pkg::mod_sub(elem_rdata, hold_ff);
               sv_we     = 1'b1;
               if (next_fits) begin
                  j_in     = j_ff + NW'(1);
                  k_in     = k_next[NW-1:0];
                  state_in = X_RDK;
               end else begin
                  i_in     = i_ff + NW'(1);
                  state_in = X_SCAN;
               end
            end else begin
               mem.wdata = dzmt_pkg::mod_add(elem_rdata, hold_ff);
               if (j_ff == NW'(1)) begin
                  i_in     = i_ff + NW'(1);
                  state_in = X_SCAN;
               end else begin
                  j_in     = j_ff - NW'(1);
                  k_in     = k_ff - i_ff;
                  state_in = X_RDK;
               end
            end
         end
         default: begin
            state_in = X_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= X_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      m_ff    <= m_in;
      mode_ff <= mode_in;
      hold_ff <= hold_in;
   end

endmodule

FILE: hw/rtl/divisor_zeta_moebius_transform.sv
// Top level of the divisor zeta / Moebius transform block over residues mod 998244353.
// Depends on dzmt_pkg, dzmt_req_if, dzmt_rsp_if, dzmt_ram and dzmt_xform.
//
// Each request beat writes one element, reads one element, or transforms
// elements 1 .. m-1 in place (m = size_in_use, capped at ARRAY_DEPTH); every
// request returns exactly one response beat, carrying the element on a read
// and zero otherwise. A read takes its data in S_READ from the registered read
// of the element RAM. A transform first refills the prime sieve, one entry a
// cycle, then scans candidates (X_SCAN, X_CHECK) and runs read-modify-write
// steps on the element RAM (X_RDK read multiple, X_RDJ read target, X_WR write
// back); zeta mode adds an X_MARK pass over the multiples of each prime. Requests
// are taken one at a time; a new request is taken while the previous response
// waits in the output register. Configuration writes go through the csr port;
// the user must make them only while idle, which the block does not enforce.
module divisor_zeta_moebius_transform #(
   parameter int ARRAY_DEPTH = dzmt_pkg::DEFAULT_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   dzmt_req_if.sink                        req_bus,
   dzmt_rsp_if.source                      rsp_bus,
   input  logic                            csr_we,
   input  logic [dzmt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dzmt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(ARRAY_DEPTH);
   localparam int DW = dzmt_pkg::DATA_W;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_XFORM = 2'd2;
   localparam logic [1:0] S_FIN   = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]               rsp_data_ff, rsp_data_in;
   logic [DW-1:0]               res_ff, res_in;
   logic                        rd_ok_ff, rd_ok_in;
   logic                        mode_ff, mode_in;
   logic [dzmt_pkg::SIZE_W-1:0] size_ff, size_in;

   logic          accept, in_range, out_free, fin_valid;
   logic [DW-1:0] fin_data, wr_value;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [DW-1:0] ram_wdata, ram_rdata;

   dzmt_pkg::xform_ctl_type x_ctl;
   dzmt_pkg::xform_mem_type x_mem;
   logic                    x_done;

   dzmt_ram #(.WIDTH(DW), .DEPTH(ARRAY_DEPTH)) u_elem (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   dzmt_xform #(.ARRAY_DEPTH(ARRAY_DEPTH)) u_xform (
      .clock      (clock),
      .reset      (reset),
      .ctl        (x_ctl),
      .elem_rdata (ram_rdata),
      .mem        (x_mem),
      .done       (x_done)
   );

   assign req_bus.ready      = (state_ff == S_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.read_value = rsp_data_ff;

   always_comb begin
      accept   = req_bus.valid && req_bus.ready;
      in_range = 32'(req_bus.index) < ARRAY_DEPTH;
      out_free = !rsp_valid_ff || rsp_bus.ready;
      wr_value = (req_bus.value >= dzmt_pkg::MODULUS) ?
                 (req_bus.value - dzmt_pkg::MODULUS) : req_bus.value;

      x_ctl.start = accept && (req_bus.action == dzmt_pkg::ACT_XFORM);
      x_ctl.mode  = mode_ff;
      x_ctl.size  = size_ff;

      // drive the element RAM from the sequencer during a transform
      if (state_ff == S_XFORM) begin
         ram_we    = x_mem.we;
         ram_waddr = AW'(x_mem.waddr);
         ram_wdata = x_mem.wdata;
         ram_re    = x_mem.re;
         ram_raddr = AW'(x_mem.raddr);
      end else begin
         ram_we    = accept && (req_bus.action == dzmt_pkg::ACT_WRITE) && in_range;
         ram_waddr = AW'(req_bus.index);
         ram_wdata = wr_value;
         ram_re    = accept && (req_bus.action == dzmt_pkg::ACT_READ) && in_range;
         ram_raddr = AW'(req_bus.index);
      end

      fin_valid = 1'b0;
      fin_data  = '0;
      state_in  = state_ff;
      rd_ok_in  = rd_ok_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_bus.action)
                  dzmt_pkg::ACT_READ: begin
                     rd_ok_in = in_range;
                     state_in = S_READ;
                  end
                  dzmt_pkg::ACT_XFORM: begin
                     state_in = S_XFORM;
                  end
                  default: begin
                     fin_valid = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            fin_valid = 1'b1;
            fin_data  = rd_ok_ff ? ram_rdata : '0;
         end
         S_XFORM: begin
            fin_valid = x_done;
         end
         S_FIN: begin
            fin_valid = 1'b1;
            fin_data  = res_ff;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // load the output register when free, else hold the result
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;
      if (fin_valid) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = fin_data;
            state_in     = S_IDLE;
         end else begin
            res_in   = fin_data;
            state_in = S_FIN;
         end
      end

      mode_in = mode_ff;
      size_in = size_ff;
      if (csr_we) begin
         case (csr_index)
            dzmt_pkg::CSR_MODE: mode_in = csr_wdata[0];
            dzmt_pkg::CSR_SIZE: size_in = csr_wdata;
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
         size_ff      <= dzmt_pkg::SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         size_ff      <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      res_ff      <= res_in;
      rd_ok_ff    <= rd_ok_in;
   end

endmodule
